// File: src/cdkb_pkg.sv
// ----------------------------------------------------------------------------
// cdkb_pkg: shared types and constants of the chroma distance key blender
// Field widths, register indexes and reset values, and the words that move
// between the front part, the queues and the back part.
// ----------------------------------------------------------------------------
package cdkb_pkg;

    // field widths
    localparam int PIX_W      = 8;
    localparam int THR_W      = 9;
    localparam int NUM_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // default queue depths
    localparam int MID_DEPTH_DEF = 8;
    localparam int OUT_DEPTH_DEF = 8;

    // blend constants
    localparam logic [PIX_W-1:0] ALPHA_FULL = 8'd255;
    localparam logic [15:0]      MIX_BIAS   = 16'd127;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_CB        = 3'd0,
        REG_KEY_CR        = 3'd1,
        REG_THR_LO        = 3'd2,
        REG_THR_HI        = 3'd3,
        REG_BG_FROM_FRAME = 3'd4,
        REG_BG_CONST_Y    = 3'd5,
        REG_BG_CONST_CB   = 3'd6,
        REG_BG_CONST_CR   = 3'd7
    } t_reg_idx;

    // register reset values
    localparam logic [PIX_W-1:0] KEY_CB_RST      = 8'd128;
    localparam logic [PIX_W-1:0] KEY_CR_RST      = 8'd128;
    localparam logic [THR_W-1:0] THR_LO_RST      = 9'd20;
    localparam logic [THR_W-1:0] THR_HI_RST      = 9'd60;
    localparam logic             BG_FRAME_RST    = 1'b0;
    localparam logic [PIX_W-1:0] BG_CONST_Y_RST  = 8'd16;
    localparam logic [PIX_W-1:0] BG_CONST_CB_RST = 8'd128;
    localparam logic [PIX_W-1:0] BG_CONST_CR_RST = 8'd128;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [PIX_W-1:0] key_cb;
        logic [PIX_W-1:0] key_cr;
        logic [THR_W-1:0] thr_lo;
        logic [THR_W-1:0] thr_hi;
        logic             bg_from_frame;
        logic [PIX_W-1:0] bg_const_y;
        logic [PIX_W-1:0] bg_const_cb;
        logic [PIX_W-1:0] bg_const_cr;
    } t_cfg;

    // one YCbCr pixel
    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } t_pel;

    // classified pixel: alpha = num / span (full and none use span 1)
    typedef struct packed {
        t_pel             fg;
        t_pel             bg;
        logic [NUM_W-1:0] num;
        logic [THR_W-1:0] span;
    } t_job;

    // front part output toward the middle queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_push;

    // one result word
    typedef struct packed {
        t_pel             pel;
        logic [PIX_W-1:0] alpha;
    } t_res;

    // back part output toward the result queue
    typedef struct packed {
        logic valid;
        t_res res;
    } t_res_push;

endpackage

// File: src/cdkb_fifo.sv
// ----------------------------------------------------------------------------
// cdkb_fifo: small register queue
// Flip-flop storage with wrap pointers and a fill count. Writers keep it
// from overflowing through credit counting, so there is no full flag.
// ----------------------------------------------------------------------------
module cdkb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: src/cdkb_front.sv
// ----------------------------------------------------------------------------
// cdkb_front: pixel intake and key classification
// Takes pixels, picks the background, measures the rounded chroma distance
// with a three stage digit-by-digit square root and turns it into an alpha
// fraction num/span for the back part.
// ----------------------------------------------------------------------------
module cdkb_front #(
    parameter int MID_DEPTH = cdkb_pkg::MID_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdkb_pkg::t_cfg      i_cfg,
    input  logic                i_push,
    output logic                o_full,
    input  cdkb_pkg::t_pel      i_fg,
    input  cdkb_pkg::t_pel      i_bg,
    input  logic                i_credit_ret,
    output cdkb_pkg::t_job_push o_job
);

    localparam int CW     = $clog2(MID_DEPTH + 1);
    localparam int SQ_STG = 4;

    // square root working state: radicand bits left, remainder, partial root
    typedef struct packed {
        logic [17:0] rad;
        logic [11:0] rem;
        logic [8:0]  root;
    } t_sq;

    function automatic t_sq sq_step(t_sq s);
        logic [11:0] acc;
        logic [11:0] trial;
        t_sq         o;
        acc   = {s.rem[9:0], s.rad[17:16]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[15:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[7:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[7:0], 1'b0};
        end
        return o;
    endfunction

    logic [CW-1:0]          r_cnt;
    logic                   w_accept;
    cdkb_pkg::t_pel         w_bg_sel;
    logic [7:0]             w_dcb, w_dcr;
    logic [15:0]            w_sqcb, w_sqcr;

    // stage 0: captured pixel and chroma differences
    logic                   r_v0;
    cdkb_pkg::t_pel         r_fg0, r_bg0;
    logic [7:0]             r_dcb0, r_dcr0;

    // square root stages (index 0 holds the sum of squares)
    logic                   r_sv  [SQ_STG];
    t_sq                    r_ss  [SQ_STG];
    cdkb_pkg::t_pel         r_sfg [SQ_STG];
    cdkb_pkg::t_pel         r_sbg [SQ_STG];
    t_sq                    w_step[1:SQ_STG-1];

    // classification
    logic                   w_round;
    logic [8:0]             w_dist;
    logic [8:0]             w_span;
    logic [16:0]            w_d17;
    logic [16:0]            w_num;
    logic [8:0]             w_div;
    logic                   r_jv;
    cdkb_pkg::t_job         r_job;

    // credit count over this part and the middle queue
    assign w_accept = i_push && !o_full;
    assign o_full   = (r_cnt == CW'(MID_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(w_accept) - CW'(i_credit_ret);
        end
    end

    // background pick and absolute chroma differences
    always_comb begin
        w_bg_sel = i_cfg.bg_from_frame ? i_bg
                 : cdkb_pkg::t_pel'{y: i_cfg.bg_const_y, cb: i_cfg.bg_const_cb,
                                    cr: i_cfg.bg_const_cr};
        w_dcb = (i_fg.cb > i_cfg.key_cb) ? i_fg.cb - i_cfg.key_cb : i_cfg.key_cb - i_fg.cb;
        w_dcr = (i_fg.cr > i_cfg.key_cr) ? i_fg.cr - i_cfg.key_cr : i_cfg.key_cr - i_fg.cr;
    end

    // squares of the differences
    assign w_sqcb = 16'(r_dcb0) * 16'(r_dcb0);
    assign w_sqcr = 16'(r_dcr0) * 16'(r_dcr0);

    // three root bits per stage
    always_comb begin
        for (int k = 1; k < SQ_STG; k++) begin
            w_step[k] = sq_step(sq_step(sq_step(r_ss[k-1])));
        end
    end

    // rounding and alpha fraction
    always_comb begin
        w_round = r_ss[SQ_STG-1].rem > 12'(r_ss[SQ_STG-1].root);
        w_dist  = r_ss[SQ_STG-1].root + 9'(w_round);
        w_span  = i_cfg.thr_hi - i_cfg.thr_lo;
        w_d17   = 17'(i_cfg.thr_hi - w_dist);
        w_num   = '0;
        w_div   = 9'd1;
        if (w_dist < i_cfg.thr_lo) begin
            w_num = 17'(cdkb_pkg::ALPHA_FULL);
        end else if (w_dist > i_cfg.thr_hi) begin
            w_num = '0;
        end else if (w_span != '0) begin
            // 255 * (outer - dist) + span / 2
            w_num = (w_d17 << 8) - w_d17 + 17'(w_span[8:1]);
            w_div = w_span;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_jv <= 1'b0;
            for (int k = 0; k < SQ_STG; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_v0    <= w_accept;
            r_sv[0] <= r_v0;
            for (int k = 1; k < SQ_STG; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_jv <= r_sv[SQ_STG-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_fg0  <= i_fg;
        r_bg0  <= w_bg_sel;
        r_dcb0 <= w_dcb;
        r_dcr0 <= w_dcr;

        r_ss[0].rad  <= {1'b0, 17'(w_sqcb) + 17'(w_sqcr)};
        r_ss[0].rem  <= '0;
        r_ss[0].root <= '0;
        r_sfg[0]     <= r_fg0;
        r_sbg[0]     <= r_bg0;
        for (int k = 1; k < SQ_STG; k++) begin
            r_ss[k]  <= w_step[k];
            r_sfg[k] <= r_sfg[k-1];
            r_sbg[k] <= r_sbg[k-1];
        end

        r_job.fg   <= r_sfg[SQ_STG-1];
        r_job.bg   <= r_sbg[SQ_STG-1];
        r_job.num  <= w_num;
        r_job.span <= w_div;
    end

    assign o_job.valid = r_jv;
    assign o_job.job   = r_job;

endmodule

// File: src/cdkb_back.sv
// ----------------------------------------------------------------------------
// cdkb_back: alpha division and plane blend
// Pulls classified pixels from the middle queue while the result queue has
// room, divides num/span two quotient bits per stage, then blends the three
// planes with a rounded divide by 255.
// ----------------------------------------------------------------------------
module cdkb_back #(
    parameter int OUT_DEPTH = cdkb_pkg::OUT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mid_empty,
    input  cdkb_pkg::t_job      i_job,
    output logic                o_mid_pop,
    input  logic                i_out_pop,
    output cdkb_pkg::t_res_push o_res
);

    localparam int CW     = $clog2(OUT_DEPTH + 1);
    localparam int DV_STG = 4;
    localparam int NPL    = 3;

    typedef struct packed {
        logic [16:0] rem;
        logic [7:0]  q;
    } t_dv;

    // one restoring quotient bit at weight k
    function automatic t_dv dv_step(t_dv s, logic [8:0] span, int unsigned k);
        logic [16:0] dsh;
        t_dv         o;
        dsh = 17'(span) << k;
        if (s.rem >= dsh) begin
            o.rem = s.rem - dsh;
            o.q   = {s.q[6:0], 1'b1};
        end else begin
            o.rem = s.rem;
            o.q   = {s.q[6:0], 1'b0};
        end
        return o;
    endfunction

    logic [CW-1:0]          r_cnt;
    logic                   w_issue;

    // divider stages
    logic                   r_dv_v  [DV_STG];
    t_dv                    r_dv    [DV_STG];
    logic [8:0]             r_span  [DV_STG-1];
    cdkb_pkg::t_pel         r_dfg   [DV_STG];
    cdkb_pkg::t_pel         r_dbg   [DV_STG];
    t_dv                    w_dv_in [DV_STG];
    t_dv                    w_dv_out[DV_STG];

    // blend stages
    logic [NPL-1:0][7:0]    w_fgv, w_bgv;
    logic [7:0]             w_alpha, w_ainv;
    logic                   r_mv;
    logic [15:0]            r_pf [NPL];
    logic [15:0]            r_pb [NPL];
    logic [7:0]             r_ma;
    logic [15:0]            w_sum [NPL];
    logic [8:0]             w_r   [NPL];
    logic [NPL-1:0][7:0]    w_q;
    logic                   r_rv;
    cdkb_pkg::t_res         r_res;

    // credit count over this part and the result queue
    assign w_issue   = !i_mid_empty && (r_cnt < CW'(OUT_DEPTH));
    assign o_mid_pop = w_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(w_issue) - CW'(i_out_pop);
        end
    end

    // two quotient bits per stage, most significant first
    always_comb begin
        for (int k = 0; k < DV_STG; k++) begin
            if (k == 0) begin
                w_dv_in[k].rem = i_job.num;
                w_dv_in[k].q   = '0;
                w_dv_out[k] = dv_step(dv_step(w_dv_in[k], i_job.span, 7),
                                      i_job.span, 6);
            end else begin
                w_dv_in[k]  = r_dv[k-1];
                w_dv_out[k] = dv_step(dv_step(w_dv_in[k], r_span[k-1],
                                              unsigned'(7 - 2 * k)),
                                      r_span[k-1], unsigned'(6 - 2 * k));
            end
        end
    end

    // plane products
    always_comb begin
        w_fgv   = r_dfg[DV_STG-1];
        w_bgv   = r_dbg[DV_STG-1];
        w_alpha = r_dv[DV_STG-1].q;
        w_ainv  = cdkb_pkg::ALPHA_FULL - w_alpha;
    end

    // rounded divide by 255: x/256 is low by at most one
    always_comb begin
        for (int p = 0; p < NPL; p++) begin
            w_sum[p] = r_pf[p] + r_pb[p] + cdkb_pkg::MIX_BIAS;
            w_r[p]   = 9'(w_sum[p][7:0]) + 9'(w_sum[p][15:8]);
            w_q[p]   = w_sum[p][15:8] + 8'(w_r[p] >= 9'd255);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DV_STG; k++) begin
                r_dv_v[k] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_dv_v[0] <= w_issue;
            for (int k = 1; k < DV_STG; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
            r_mv <= r_dv_v[DV_STG-1];
            r_rv <= r_mv;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_dv[0]   <= w_dv_out[0];
        r_span[0] <= i_job.span;
        r_dfg[0]  <= i_job.fg;
        r_dbg[0]  <= i_job.bg;
        for (int k = 1; k < DV_STG; k++) begin
            r_dv[k]   <= w_dv_out[k];
            r_dfg[k]  <= r_dfg[k-1];
            r_dbg[k]  <= r_dbg[k-1];
        end
        // the last stage needs no divisor
        for (int k = 1; k < DV_STG - 1; k++) begin
            r_span[k] <= r_span[k-1];
        end

        for (int p = 0; p < NPL; p++) begin
            r_pf[p] <= 16'(w_fgv[p]) * 16'(w_ainv);
            r_pb[p] <= 16'(w_bgv[p]) * 16'(w_alpha);
        end
        r_ma <= w_alpha;

        r_res.pel   <= w_q;
        r_res.alpha <= r_ma;
    end

    assign o_res.valid = r_rv;
    assign o_res.res   = r_res;

endmodule

// File: src/chroma_distance_key_blend.sv
// ----------------------------------------------------------------------------
// chroma_distance_key_blend: chroma distance keyer with alpha blend
// Keys a 4:4:4 YCbCr pixel on its rounded Cb/Cr distance to a key colour and
// blends it over a constant or per-pixel background.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------
//   pixel in  i_fg_y/cb/cr, i_bg_y/cb/cr              push, full
//   result    o_out_y/cb/cr, o_key_alpha              empty, pop
//   config    i_cfg_we, i_cfg_idx, i_cfg_data         write enable only
//
// One word per clock sustained while full stays low and the receiver pops.
// A pushed word passes six stages in the front part (three of them the
// square root), one in the middle queue, six in the back part (four of
// them the alpha divider) and one in the result queue before its pop.
// Reset is synchronous, active low; it empties both queues at once.
// full rises once MID_DEPTH words sit in the front part and middle queue;
// the back part stops pulling at OUT_DEPTH words in it and the result queue.
// ----------------------------------------------------------------------------
module chroma_distance_key_blend #(
    parameter int MID_DEPTH = cdkb_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = cdkb_pkg::OUT_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [cdkb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cdkb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // pixel in
    input  logic                              push,
    output logic                              full,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_fg_y,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_fg_cb,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_fg_cr,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_bg_y,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_bg_cb,
    input  logic [cdkb_pkg::PIX_W-1:0]        i_bg_cr,
    // result
    output logic                              empty,
    input  logic                              pop,
    output logic [cdkb_pkg::PIX_W-1:0]        o_out_y,
    output logic [cdkb_pkg::PIX_W-1:0]        o_out_cb,
    output logic [cdkb_pkg::PIX_W-1:0]        o_out_cr,
    output logic [cdkb_pkg::PIX_W-1:0]        o_key_alpha
);

    cdkb_pkg::t_cfg      r_cfg;
    cdkb_pkg::t_pel      w_fg, w_bg;
    cdkb_pkg::t_job_push w_job_push;
    cdkb_pkg::t_job      w_mid_head;
    logic                w_mid_empty;
    logic                w_mid_pop;
    cdkb_pkg::t_res_push w_res_push;
    cdkb_pkg::t_res      w_out_head;
    logic                w_out_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_cb        <= cdkb_pkg::KEY_CB_RST;
            r_cfg.key_cr        <= cdkb_pkg::KEY_CR_RST;
            r_cfg.thr_lo        <= cdkb_pkg::THR_LO_RST;
            r_cfg.thr_hi        <= cdkb_pkg::THR_HI_RST;
            r_cfg.bg_from_frame <= cdkb_pkg::BG_FRAME_RST;
            r_cfg.bg_const_y    <= cdkb_pkg::BG_CONST_Y_RST;
            r_cfg.bg_const_cb   <= cdkb_pkg::BG_CONST_CB_RST;
            r_cfg.bg_const_cr   <= cdkb_pkg::BG_CONST_CR_RST;
        end else if (i_cfg_we) begin
            case (cdkb_pkg::t_reg_idx'(i_cfg_idx))
                cdkb_pkg::REG_KEY_CB:        r_cfg.key_cb        <= i_cfg_data[7:0];
                cdkb_pkg::REG_KEY_CR:        r_cfg.key_cr        <= i_cfg_data[7:0];
                cdkb_pkg::REG_THR_LO:        r_cfg.thr_lo        <= i_cfg_data;
                cdkb_pkg::REG_THR_HI:        r_cfg.thr_hi        <= i_cfg_data;
                cdkb_pkg::REG_BG_FROM_FRAME: r_cfg.bg_from_frame <= i_cfg_data[0];
                cdkb_pkg::REG_BG_CONST_Y:    r_cfg.bg_const_y    <= i_cfg_data[7:0];
                cdkb_pkg::REG_BG_CONST_CB:   r_cfg.bg_const_cb   <= i_cfg_data[7:0];
                cdkb_pkg::REG_BG_CONST_CR:   r_cfg.bg_const_cr   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_fg = '{y: i_fg_y, cb: i_fg_cb, cr: i_fg_cr};
    assign w_bg = '{y: i_bg_y, cb: i_bg_cb, cr: i_bg_cr};

    // intake and classification
    cdkb_front #(
        .MID_DEPTH (MID_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_push       (push),
        .o_full       (full),
        .i_fg         (w_fg),
        .i_bg         (w_bg),
        .i_credit_ret (w_mid_pop),
        .o_job        (w_job_push)
    );

    // middle queue
    cdkb_fifo #(
        .WIDTH ($bits(cdkb_pkg::t_job)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push.valid),
        .i_data  (w_job_push.job),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_head),
        .o_empty (w_mid_empty)
    );

    // division and blend
    cdkb_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (w_mid_empty),
        .i_job       (w_mid_head),
        .o_mid_pop   (w_mid_pop),
        .i_out_pop   (w_out_pop),
        .o_res       (w_res_push)
    );

    // result queue
    assign w_out_pop = pop && !empty;

    cdkb_fifo #(
        .WIDTH ($bits(cdkb_pkg::t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push.valid),
        .i_data  (w_res_push.res),
        .i_pop   (w_out_pop),
        .o_data  (w_out_head),
        .o_empty (empty)
    );

    assign o_out_y     = w_out_head.pel.y;
    assign o_out_cb    = w_out_head.pel.cb;
    assign o_out_cr    = w_out_head.pel.cr;
    assign o_key_alpha = w_out_head.alpha;

endmodule

// File: bench/chroma_distance_key_blend_tb.sv
// ----------------------------------------------------------------------------
// chroma_distance_key_blend_tb: self-checking bench for the chroma keyer
// Pushes foreground/background pixels through the keyer and checks every
// popped word against an in-bench model of the distance, ramp and blend.
// Coverage: reset settings, threshold corners (equal, crossed, 0 and 511),
// constant and frame backgrounds, random sweeps over many register sets,
// and a long receiver hold-off that backs the pipeline up to full.
// ----------------------------------------------------------------------------
module chroma_distance_key_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdkb_pkg::*;

    localparam int ALPHA_MAX    = 255;
    localparam int BLEND_ROUND  = 127;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int SWEEP_PHASES = 9;
    localparam int SWEEP_WORDS  = 115;
    localparam int BURST_WORDS  = 90;
    localparam int CFG_BITS     = $bits(t_cfg);
    localparam int PEL_BITS     = $bits(t_pel);

    // DUT-facing signals; the inputs are known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push       = 1'b0;
    logic                  full;
    logic [PIX_W-1:0]      i_fg_y     = '0;
    logic [PIX_W-1:0]      i_fg_cb    = '0;
    logic [PIX_W-1:0]      i_fg_cr    = '0;
    logic [PIX_W-1:0]      i_bg_y     = '0;
    logic [PIX_W-1:0]      i_bg_cb    = '0;
    logic [PIX_W-1:0]      i_bg_cr    = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    logic [PIX_W-1:0]      o_out_y;
    logic [PIX_W-1:0]      o_out_cb;
    logic [PIX_W-1:0]      o_out_cr;
    logic [PIX_W-1:0]      o_key_alpha;

    // bench state
    t_cfg cfg_now;
    t_res pending_blends[$];
    int   mismatch_cnt = 0;
    int   hold_reqs    = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   stall_left   = 0;
    int   calm_left    = 0;

    chroma_distance_key_blend i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_fg_y      (i_fg_y),
        .i_fg_cb     (i_fg_cb),
        .i_fg_cr     (i_fg_cr),
        .i_bg_y      (i_bg_y),
        .i_bg_cb     (i_bg_cb),
        .i_bg_cr     (i_bg_cr),
        .empty       (empty),
        .pop         (pop),
        .o_out_y     (o_out_y),
        .o_out_cb    (o_out_cb),
        .o_out_cr    (o_out_cr),
        .o_key_alpha (o_key_alpha)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // model of the keyer
    // ------------------------------------------------------------------

    // one plane: replace, keep, or rounded mix
    function automatic logic [PIX_W-1:0] blend_plane(logic [PIX_W-1:0] f,
                                                     logic [PIX_W-1:0] b, int a);
        int v;
        if (a == ALPHA_MAX) return b;
        if (a == 0) return f;
        v = (int'(f) * (ALPHA_MAX - a) + int'(b) * a + BLEND_ROUND) / ALPHA_MAX;
        return v[PIX_W-1:0];
    endfunction

    function automatic t_res predict_blend(t_pel fg, t_pel frame_bg);
        t_pel bg;
        int   dcb, dcr, sq, root, key_dist, alpha, span, inner, outer;
        t_res r;
        if (cfg_now.bg_from_frame) begin
            bg = frame_bg;
        end else begin
            bg.y  = cfg_now.bg_const_y;
            bg.cb = cfg_now.bg_const_cb;
            bg.cr = cfg_now.bg_const_cr;
        end
        dcb = int'(fg.cb) - int'(cfg_now.key_cb);
        dcr = int'(fg.cr) - int'(cfg_now.key_cr);
        if (dcb < 0) dcb = -dcb;
        if (dcr < 0) dcr = -dcr;
        sq = dcb * dcb + dcr * dcr;
        // floor root by counting up, then round to nearest
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        key_dist = (sq > root * root + root) ? root + 1 : root;
        inner = int'(cfg_now.thr_lo);
        outer = int'(cfg_now.thr_hi);
        if (key_dist < inner) begin
            alpha = ALPHA_MAX;
        end else if (key_dist > outer) begin
            alpha = 0;
        end else begin
            span = outer - inner;
            // equal thresholds: no ramp, key off
            alpha = (span == 0) ? 0
                  : (ALPHA_MAX * (outer - key_dist) + span / 2) / span;
        end
        r.alpha  = alpha[PIX_W-1:0];
        r.pel.y  = blend_plane(fg.y, bg.y, alpha);
        r.pel.cb = blend_plane(fg.cb, bg.cb, alpha);
        r.pel.cr = blend_plane(fg.cr, bg.cr, alpha);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [PIX_W-1:0] want,
                               logic [PIX_W-1:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    task automatic check_blend();
        t_res want;
        if (pending_blends.size() == 0) begin
            mismatch_cnt++;
            $display("%0t ns: unexpected word, expected none, actual y=%0d cb=%0d cr=%0d a=%0d",
                     $time, o_out_y, o_out_cb, o_out_cr, o_key_alpha);
        end else begin
            want = pending_blends.pop_front();
            check_field("out_y", want.pel.y, o_out_y);
            check_field("out_cb", want.pel.cb, o_out_cb);
            check_field("out_cr", want.pel.cr, o_out_cr);
            check_field("key_alpha", want.alpha, o_key_alpha);
        end
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // receiver: checks each popped word, then picks the next pop value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_blend();
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                pop <= 1'b1;
            end else if ($urandom_range(0, 99) < 3) begin
                calm_left = $urandom_range(40, 200);
                pop <= 1'b1;
            end else begin
                stall_left = idle_len();
                pop <= (stall_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // pixel side
    // ------------------------------------------------------------------

    // offer one word, hold it until taken, then idle for gap cycles
    task automatic push_pixel(t_pel fg, t_pel bg, int gap);
        i_fg_y  <= fg.y;
        i_fg_cb <= fg.cb;
        i_fg_cr <= fg.cr;
        i_bg_y  <= bg.y;
        i_bg_cb <= bg.cb;
        i_bg_cr <= bg.cr;
        push    <= 1'b1;
        do @(posedge i_clk); while (full);
        pending_blends.push_back(predict_blend(fg, bg));
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // foreground at a chroma offset from the current key
    task automatic push_offset(int dcb, int dcr, logic [PIX_W-1:0] y, t_pel bg);
        t_pel fg;
        fg.y  = y;
        fg.cb = PIX_W'(int'(cfg_now.key_cb) + dcb);
        fg.cr = PIX_W'(int'(cfg_now.key_cr) + dcr);
        push_pixel(fg, bg, idle_len());
    endtask

    // stop offering and wait until every word has been popped
    task automatic wait_all_done();
        push <= 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
    endtask

    // write all registers, with random junk in the unused data bits
    task automatic load_config(t_cfg c);
        logic [CFG_DATA_W-1:0] word;
        t_reg_idx              idx;
        idx = idx.first();
        repeat (idx.num()) begin
            word = CFG_DATA_W'($urandom);
            case (idx)
                REG_KEY_CB:        word[PIX_W-1:0] = c.key_cb;
                REG_KEY_CR:        word[PIX_W-1:0] = c.key_cr;
                REG_THR_LO:        word = c.thr_lo;
                REG_THR_HI:        word = c.thr_hi;
                REG_BG_FROM_FRAME: word[0] = c.bg_from_frame;
                REG_BG_CONST_Y:    word[PIX_W-1:0] = c.bg_const_y;
                REG_BG_CONST_CB:   word[PIX_W-1:0] = c.bg_const_cb;
                REG_BG_CONST_CR:   word[PIX_W-1:0] = c.bg_const_cr;
                default: ;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= word;
            @(posedge i_clk);
            // mirror what the register keeps after masking
            case (idx)
                REG_KEY_CB:        cfg_now.key_cb        = word[PIX_W-1:0];
                REG_KEY_CR:        cfg_now.key_cr        = word[PIX_W-1:0];
                REG_THR_LO:        cfg_now.thr_lo        = word[THR_W-1:0];
                REG_THR_HI:        cfg_now.thr_hi        = word[THR_W-1:0];
                REG_BG_FROM_FRAME: cfg_now.bg_from_frame = word[0];
                REG_BG_CONST_Y:    cfg_now.bg_const_y    = word[PIX_W-1:0];
                REG_BG_CONST_CB:   cfg_now.bg_const_cb   = word[PIX_W-1:0];
                REG_BG_CONST_CR:   cfg_now.bg_const_cr   = word[PIX_W-1:0];
                default: ;
            endcase
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [PIX_W-1:0] rand_near(int center, int reach);
        int v;
        v = $urandom_range(0, 1) ? center + $urandom_range(0, reach)
                                 : center - $urandom_range(0, reach);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[PIX_W-1:0];
    endfunction

    function automatic t_pel rand_pel();
        t_pel p;
        if ($urandom_range(0, 9) == 0) begin
            p.y  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.cb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            p.cr = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end else begin
            p = t_pel'(PEL_BITS'($urandom));
        end
        return p;
    endfunction

    // foreground: uniform, or clustered around the key to land on the ramp
    function automatic t_pel rand_fg();
        t_pel p;
        int   reach;
        p = rand_pel();
        if ($urandom_range(0, 9) < 5) begin
            reach = int'(cfg_now.thr_hi) + 8;
            if (reach > 255) reach = 255;
            p.cb = rand_near(int'(cfg_now.key_cb), reach);
            p.cr = rand_near(int'(cfg_now.key_cr), reach);
        end
        return p;
    endfunction

    function automatic t_cfg rand_config(int phase);
        t_cfg c;
        c = t_cfg'(CFG_BITS'({$urandom, $urandom}));
        case (phase)
            0: begin
                c.key_cb = 8'd128; c.key_cr = 8'd128;
                c.thr_lo = 9'd20; c.thr_hi = 9'd60;
                c.bg_from_frame = 1'b0;
            end
            1: begin
                c.key_cb = 8'd0; c.key_cr = 8'd0;
                c.thr_lo = 9'd0; c.thr_hi = 9'd511;
                c.bg_from_frame = 1'b1;
            end
            2: begin
                c.key_cb = 8'd255; c.key_cr = 8'd255;
                c.thr_lo = 9'd511; c.thr_hi = 9'd0;
                c.bg_from_frame = 1'b0;
                c.bg_const_y = 8'd0; c.bg_const_cb = 8'd0; c.bg_const_cr = 8'd0;
            end
            3: begin
                c.key_cb = 8'd0; c.key_cr = 8'd255;
                c.thr_lo = THR_W'($urandom_range(0, 200));
                c.thr_hi = c.thr_lo;
                c.bg_from_frame = 1'b1;
                c.bg_const_y = 8'd255; c.bg_const_cb = 8'd255; c.bg_const_cr = 8'd255;
            end
            default: begin
                // mostly ordered thresholds near real distances
                if ($urandom_range(0, 4) != 0) begin
                    c.thr_lo = THR_W'($urandom_range(0, 120));
                    c.thr_hi = c.thr_lo + THR_W'($urandom_range(0, 120));
                end
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values, ramp edges and rounding of the distance
    task automatic test_reset_defaults();
        push_offset(0, 0, 8'd0, rand_pel());
        push_offset(19, 0, 8'd255, rand_pel());
        push_offset(20, 0, 8'd128, rand_pel());
        push_offset(40, 0, 8'd0, rand_pel());
        push_offset(36, 48, 8'd255, rand_pel());
        push_offset(61, 0, 8'd77, rand_pel());
        push_offset(-128, -128, 8'd255, '1);
        push_offset(127, 127, 8'd0, '0);
        push_offset(31, 31, 8'd200, rand_pel());
        push_offset(-30, 30, 8'd5, rand_pel());
        wait_all_done();
    endtask

    // equal thresholds, crossed thresholds, threshold extremes
    task automatic test_threshold_corners();
        t_cfg c;
        // equal thresholds with frame background
        c = cfg_now;
        c.key_cb = 8'd128; c.key_cr = 8'd128;
        c.thr_lo = 9'd40; c.thr_hi = 9'd40;
        c.bg_from_frame = 1'b1;
        load_config(c);
        push_offset(40, 0, 8'd255, '0);
        push_offset(39, 0, 8'd0, '1);
        push_offset(0, -41, 8'd128, rand_pel());
        wait_all_done();
        // inner above outer: step with no ramp
        c.key_cb = 8'd0; c.key_cr = 8'd255;
        c.thr_lo = 9'd100; c.thr_hi = 9'd50;
        c.bg_from_frame = 1'b0;
        load_config(c);
        push_offset(99, 0, 8'd10, rand_pel());
        push_offset(100, 0, 8'd20, rand_pel());
        push_offset(75, 0, 8'd30, rand_pel());
        wait_all_done();
        // both thresholds zero
        c.key_cb = 8'd255; c.key_cr = 8'd0;
        c.thr_lo = 9'd0; c.thr_hi = 9'd0;
        load_config(c);
        push_offset(0, 0, 8'd90, rand_pel());
        push_offset(-1, 0, 8'd91, rand_pel());
        wait_all_done();
        // both thresholds at maximum: always keyed
        c.thr_lo = 9'd511; c.thr_hi = 9'd511;
        load_config(c);
        push_offset(-255, 255, 8'd255, rand_pel());
        wait_all_done();
        // widest ramp with frame background
        c.thr_lo = 9'd0; c.thr_hi = 9'd511;
        c.bg_from_frame = 1'b1;
        load_config(c);
        push_offset(0, 0, 8'd0, '1);
        push_offset(-255, 255, 8'd255, '0);
        wait_all_done();
    endtask

    // random pixels over a series of register sets
    task automatic test_random_sweep();
        int gaps_on;
        for (int ph = 0; ph < SWEEP_PHASES; ph++) begin
            load_config(rand_config(ph));
            gaps_on = ph % 2;
            repeat (SWEEP_WORDS)
                push_pixel(rand_fg(), rand_pel(), gaps_on ? idle_len() : 0);
            wait_all_done();
        end
    endtask

    // receiver holds off while words keep coming: pipeline fills, full rises
    task automatic test_fifo_backpressure();
        load_config(rand_config(SWEEP_PHASES));
        hold_reqs <= hold_reqs + 1;
        repeat (BURST_WORDS) push_pixel(rand_fg(), rand_pel(), 0);
        wait_all_done();
    endtask

    // main sequence
    initial begin
        cfg_now.key_cb        = KEY_CB_RST;
        cfg_now.key_cr        = KEY_CR_RST;
        cfg_now.thr_lo        = THR_LO_RST;
        cfg_now.thr_hi        = THR_HI_RST;
        cfg_now.bg_from_frame = BG_FRAME_RST;
        cfg_now.bg_const_y    = BG_CONST_Y_RST;
        cfg_now.bg_const_cb   = BG_CONST_CB_RST;
        cfg_now.bg_const_cr   = BG_CONST_CR_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_threshold_corners();
        test_random_sweep();
        test_fifo_backpressure();

        wait_all_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
